// ----- design/aar_pkg.sv -----
// Shared types and fixed-point constants for the axis-angle rotation matrix block.
`default_nettype none
package aar_pkg;
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS = DATA_WIDTH - 2;
   localparam int OUT_SHIFT = 62 - DATA_WIDTH;
   localparam int ANG_W = 36;
   localparam int CW = 34;
   localparam int UW = 32;
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES = 31;
   localparam int NORM_LAT = SQRT_STAGES + DIV_STAGES + 3;
   localparam int MAT_LAT = 3;

   localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30 = 36'sd6746518852;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;

   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
      32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
      32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
      32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
   };

   typedef struct packed {
      logic signed [15:0] angle_rad;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] m00;
      logic signed [DATA_WIDTH-1:0] m01;
      logic signed [DATA_WIDTH-1:0] m02;
      logic signed [DATA_WIDTH-1:0] m10;
      logic signed [DATA_WIDTH-1:0] m11;
      logic signed [DATA_WIDTH-1:0] m12;
      logic signed [DATA_WIDTH-1:0] m20;
      logic signed [DATA_WIDTH-1:0] m21;
      logic signed [DATA_WIDTH-1:0] m22;
      logic degenerate_axis;
   } rsp_type;
endpackage
`default_nettype wire

// ----- design/aar_cordic.sv -----
// Angle range reduction and pipelined rotation-mode CORDIC giving cosine and sine.
`default_nettype none
module aar_cordic #(
   parameter int STAGES = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [15:0]            angle,
   output logic signed [aar_pkg::UW-1:0] cos_out,
   output logic signed [aar_pkg::UW-1:0] sin_out
);
   import aar_pkg::*;

   logic signed [ANG_W-1:0] a_in;
   logic signed [ANG_W-1:0] a1_in, a1_ff;
   logic signed [ANG_W-1:0] z0_wide;
   logic                    flip0_in;
   logic signed [CW-1:0]    x_ff [STAGES+1];
   logic signed [CW-1:0]    y_ff [STAGES+1];
   logic signed [CW-1:0]    z_ff [STAGES+1];
   logic                    flip_ff [STAGES+1];
   logic signed [CW-1:0]    cos_in, sin_in;
   logic signed [UW-1:0]    cos_ff, sin_ff;

   assign a_in = {{2{angle[15]}}, angle, 18'b0};

   // one wrap by 2*pi covers the whole input range
   always_comb begin
      priority if (a_in > PI_Q30) begin
         a1_in = a_in - TWO_PI_Q30;
      end else if (a_in < -PI_Q30) begin
         a1_in = a_in + TWO_PI_Q30;
      end else begin
         a1_in = a_in;
      end
   end

   always_comb begin
      priority if (a1_ff > HALF_PI_Q30) begin
         z0_wide  = a1_ff - PI_Q30;
         flip0_in = 1'b1;
      end else if (a1_ff < -HALF_PI_Q30) begin
         z0_wide  = a1_ff + PI_Q30;
         flip0_in = 1'b1;
      end else begin
         z0_wide  = a1_ff;
         flip0_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff      <= a1_in;
         x_ff[0]    <= CORDIC_GAIN_Q30;
         y_ff[0]    <= '0;
         z_ff[0]    <= z0_wide[CW-1:0];
         flip_ff[0] <= flip0_in;
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic signed [CW-1:0] dx, dy, tk;
      logic signed [CW-1:0] x_in, y_in, z_in;
      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;
      assign tk = $signed({2'b00, ATAN_TABLE[k]});
      always_comb begin
         if (!z_ff[k][CW-1]) begin
            x_in = x_ff[k] - dx;
            y_in = y_ff[k] + dy;
            z_in = z_ff[k] - tk;
         end else begin
            x_in = x_ff[k] + dx;
            y_in = y_ff[k] - dy;
            z_in = z_ff[k] + tk;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            z_ff[k+1]    <= z_in;
            flip_ff[k+1] <= flip_ff[k];
         end
      end
   end

   assign cos_in = flip_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
   assign sin_in = flip_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in[UW-1:0];
         sin_ff <= sin_in[UW-1:0];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule
`default_nettype wire

// ----- design/aar_norm.sv -----
// Axis normalization: squared length, pipelined square root and three pipelined dividers.
`default_nettype none
module aar_norm (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [15:0]            axis_x,
   input  logic signed [15:0]            axis_y,
   input  logic signed [15:0]            axis_z,
   output logic signed [aar_pkg::UW-1:0] ux,
   output logic signed [aar_pkg::UW-1:0] uy,
   output logic signed [aar_pkg::UW-1:0] uz
);
   import aar_pkg::*;

   localparam int SQ = SQRT_STAGES;
   localparam int DV = DIV_STAGES;

   logic signed [15:0] v_in [3];
   logic [15:0]        mag_in [3];
   logic [31:0]        sq_ff [3];
   logic [15:0]        mag_ff [3];
   logic [2:0]         neg_ff;
   logic [31:0]        n2_ff;
   logic [15:0]        mag1_ff [3];
   logic [2:0]         neg1_ff;

   logic [33:0] rem_ff [SQ];
   logic [31:0] root_ff [SQ];
   logic [63:0] rad_ff [SQ];
   logic [15:0] smag_ff [SQ][3];
   logic [2:0]  sneg_ff [SQ];

   logic [31:0] dr_ff [DV][3];
   logic [30:0] q_ff [DV][3];
   logic [30:0] low_ff [DV];
   logic [31:0] r_ff [DV];
   logic [2:0]  dneg_ff [DV];

   logic signed [UW-1:0] u_ff [3];

   assign v_in[0] = axis_x;
   assign v_in[1] = axis_y;
   assign v_in[2] = axis_z;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag_in[l] = v_in[l][15] ? 16'(-v_in[l]) : v_in[l];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            sq_ff[l]   <= 32'(mag_in[l]) * 32'(mag_in[l]);
            mag_ff[l]  <= mag_in[l];
            neg_ff[l]  <= v_in[l][15];
         end
         n2_ff   <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         mag1_ff <= mag_ff;
         neg1_ff <= neg_ff;
      end
   end

   // square root of n2 * 2^32, one root bit per stage
   for (genvar j = 0; j < SQ; j++) begin : g_sqrt
      logic [33:0] rem_src;
      logic [31:0] root_src;
      logic [63:0] rad_src;
      logic [15:0] mag_src [3];
      logic [2:0]  neg_src;
      logic [35:0] rem_sh, trial;
      logic        ge;
      if (j == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = {n2_ff, 32'b0};
         assign mag_src  = mag1_ff;
         assign neg_src  = neg1_ff;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
         assign rad_src  = rad_ff[j-1];
         assign mag_src  = smag_ff[j-1];
         assign neg_src  = sneg_ff[j-1];
      end
      assign rem_sh = {rem_src, rad_src[63:62]};
      assign trial  = {2'b00, root_src, 2'b01};
      assign ge     = rem_sh >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
            root_ff[j] <= {root_src[30:0], ge};
            rad_ff[j]  <= {rad_src[61:0], 2'b00};
            smag_ff[j] <= mag_src;
            sneg_ff[j] <= neg_src;
         end
      end
   end

   // (mag * 2^46 + r/2) / r, restoring, one quotient bit per stage
   for (genvar j = 0; j < DV; j++) begin : g_div
      logic [31:0] r_src;
      logic [30:0] low_src;
      logic [31:0] drem_src [3];
      logic [30:0] q_src [3];
      logic [2:0]  neg_src;
      logic [32:0] rs [3];
      logic [2:0]  ge;
      logic [31:0] rem_in [3];
      logic [30:0] q_in [3];
      if (j == 0) begin : g_first
         always_comb begin
            r_src   = root_ff[SQ-1];
            low_src = root_ff[SQ-1][31:1];
            neg_src = sneg_ff[SQ-1];
            for (int l = 0; l < 3; l++) begin
               drem_src[l] = {1'b0, smag_ff[SQ-1][l], 15'b0};
               q_src[l]    = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            r_src    = r_ff[j-1];
            low_src  = low_ff[j-1];
            neg_src  = dneg_ff[j-1];
            drem_src = dr_ff[j-1];
            q_src    = q_ff[j-1];
         end
      end
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            rs[l]     = {drem_src[l], low_src[30]};
            ge[l]     = rs[l] >= {1'b0, r_src};
            rem_in[l] = ge[l] ? 32'(rs[l] - {1'b0, r_src}) : rs[l][31:0];
            q_in[l]   = {q_src[l][29:0], ge[l]};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dr_ff[j]   <= rem_in;
            q_ff[j]    <= q_in;
            low_ff[j]  <= {low_src[29:0], 1'b0};
            r_ff[j]    <= r_src;
            dneg_ff[j] <= neg_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            u_ff[l] <= dneg_ff[DV-1][l] ? -$signed({1'b0, q_ff[DV-1][l]})
                                        : $signed({1'b0, q_ff[DV-1][l]});
         end
      end
   end

   assign ux = u_ff[0];
   assign uy = u_ff[1];
   assign uz = u_ff[2];
endmodule
`default_nettype wire

// ----- design/aar_mat.sv -----
// Rodrigues matrix assembly: axis products, trig products, rounding and saturation.
`default_nettype none
module aar_mat (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [aar_pkg::UW-1:0] ux,
   input  logic signed [aar_pkg::UW-1:0] uy,
   input  logic signed [aar_pkg::UW-1:0] uz,
   input  logic signed [aar_pkg::UW-1:0] c,
   input  logic signed [aar_pkg::UW-1:0] s,
   input  logic                          deg,
   output aar_pkg::rsp_type              mat
);
   import aar_pkg::*;

   localparam logic signed [63:0] RND30 = 64'sd536870912;
   localparam logic signed [63:0] RND_OUT = 64'sd1 <<< (OUT_SHIFT - 1);
   localparam logic signed [63:0] MAXV = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] MINV = -(64'sd1 <<< (DATA_WIDTH - 1));
   localparam logic signed [DATA_WIDTH-1:0] ONE_OUT = DATA_WIDTH'(1) <<< FRAC_BITS;

   function automatic logic signed [DATA_WIDTH-1:0] to_out(input logic signed [63:0] e);
      logic signed [63:0] v;
      v = (e + RND_OUT) >>> OUT_SHIFT;
      priority if (v > MAXV) begin
         to_out = MAXV[DATA_WIDTH-1:0];
      end else if (v < MINV) begin
         to_out = MINV[DATA_WIDTH-1:0];
      end else begin
         to_out = v[DATA_WIDTH-1:0];
      end
   endfunction

   // stage 0: u_a * u_b rounded to 2^-30
   logic signed [63:0] pxx, pyy, pzz, pxy, pxz, pyz;
   logic signed [63:0] rxx, ryy, rzz, rxy, rxz, ryz;
   logic signed [CW-1:0] uxx_ff, uyy_ff, uzz_ff, uxy_ff, uxz_ff, uyz_ff;
   logic signed [32:0] t_in, t_ff;
   logic signed [UW-1:0] ux0_ff, uy0_ff, uz0_ff, c0_ff, s0_ff;
   logic deg0_ff;

   assign pxx = 64'(ux) * 64'(ux);
   assign pyy = 64'(uy) * 64'(uy);
   assign pzz = 64'(uz) * 64'(uz);
   assign pxy = 64'(ux) * 64'(uy);
   assign pxz = 64'(ux) * 64'(uz);
   assign pyz = 64'(uy) * 64'(uz);
   assign rxx = (pxx + RND30) >>> 30;
   assign ryy = (pyy + RND30) >>> 30;
   assign rzz = (pzz + RND30) >>> 30;
   assign rxy = (pxy + RND30) >>> 30;
   assign rxz = (pxz + RND30) >>> 30;
   assign ryz = (pyz + RND30) >>> 30;
   assign t_in = 33'sd1073741824 - 33'(c);

   always_ff @(posedge clock) begin
      if (en) begin
         uxx_ff  <= rxx[CW-1:0];
         uyy_ff  <= ryy[CW-1:0];
         uzz_ff  <= rzz[CW-1:0];
         uxy_ff  <= rxy[CW-1:0];
         uxz_ff  <= rxz[CW-1:0];
         uyz_ff  <= ryz[CW-1:0];
         t_ff    <= t_in;
         ux0_ff  <= ux;
         uy0_ff  <= uy;
         uz0_ff  <= uz;
         c0_ff   <= c;
         s0_ff   <= s;
         deg0_ff <= deg;
      end
   end

   // stage 1: products against sine, cosine and 1 - cosine
   logic signed [CW-1:0] dxx, dyy, dzz;
   logic signed [63:0] qdx, qdy, qdz, qxy, qxz, qyz, qsx, qsy, qsz;
   logic signed [63:0] qdx_ff, qdy_ff, qdz_ff, qxy_ff, qxz_ff, qyz_ff;
   logic signed [63:0] qsx_ff, qsy_ff, qsz_ff;
   logic signed [CW-1:0] uxx1_ff, uyy1_ff, uzz1_ff;
   logic deg1_ff;

   assign dxx = ONE_Q30 - uxx_ff;
   assign dyy = ONE_Q30 - uyy_ff;
   assign dzz = ONE_Q30 - uzz_ff;
   assign qdx = 64'(dxx) * 64'(c0_ff);
   assign qdy = 64'(dyy) * 64'(c0_ff);
   assign qdz = 64'(dzz) * 64'(c0_ff);
   assign qxy = 64'(uxy_ff) * 64'(t_ff);
   assign qxz = 64'(uxz_ff) * 64'(t_ff);
   assign qyz = 64'(uyz_ff) * 64'(t_ff);
   assign qsx = 64'(ux0_ff) * 64'(s0_ff);
   assign qsy = 64'(uy0_ff) * 64'(s0_ff);
   assign qsz = 64'(uz0_ff) * 64'(s0_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         qdx_ff  <= qdx;
         qdy_ff  <= qdy;
         qdz_ff  <= qdz;
         qxy_ff  <= qxy;
         qxz_ff  <= qxz;
         qyz_ff  <= qyz;
         qsx_ff  <= qsx;
         qsy_ff  <= qsy;
         qsz_ff  <= qsz;
         uxx1_ff <= uxx_ff;
         uyy1_ff <= uyy_ff;
         uzz1_ff <= uzz_ff;
         deg1_ff <= deg0_ff;
      end
   end

   // stage 2: sums in 2^-60, round, clamp; identity matrix for a degenerate axis
   logic signed [63:0] bxx, byy, bzz;
   rsp_type mat_in, mat_ff;

   assign bxx = 64'(uxx1_ff);
   assign byy = 64'(uyy1_ff);
   assign bzz = 64'(uzz1_ff);

   always_comb begin
      if (deg1_ff) begin
         mat_in = '0;
         mat_in.m00 = ONE_OUT;
         mat_in.m11 = ONE_OUT;
         mat_in.m22 = ONE_OUT;
         mat_in.degenerate_axis = 1'b1;
      end else begin
         mat_in.m00 = to_out((bxx <<< 30) + qdx_ff);
         mat_in.m01 = to_out(qxy_ff - qsz_ff);
         mat_in.m02 = to_out(qxz_ff + qsy_ff);
         mat_in.m10 = to_out(qxy_ff + qsz_ff);
         mat_in.m11 = to_out((byy <<< 30) + qdy_ff);
         mat_in.m12 = to_out(qyz_ff - qsx_ff);
         mat_in.m20 = to_out(qxz_ff - qsy_ff);
         mat_in.m21 = to_out(qyz_ff + qsx_ff);
         mat_in.m22 = to_out((bzz <<< 30) + qdz_ff);
         mat_in.degenerate_axis = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mat_ff <= mat_in;
      end
   end

   assign mat = mat_ff;
endmodule
`default_nettype wire

// ----- design/axis_angle_rotation_matrix.sv -----
// The delay from an accepted req word to rsp_valid does not depend on CORDIC_STAGES.
// Throughput: one word per cycle while the skid is empty; the 32-stage square root and
// 31-stage dividers set the depth, each stage handling one result bit.
// A two-entry output (register plus skid) lets the pipe run while a result waits, until the skid fills.
// Reset (synchronous) clears all valid bits and the output and skid valid flags.
`default_nettype none
module axis_angle_rotation_matrix #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aar_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output aar_pkg::rsp_type rsp_data
);
   import aar_pkg::*;

   localparam int TOTAL = NORM_LAT + MAT_LAT;
   localparam int DLY = NORM_LAT - CORDIC_STAGES - 3;

   logic en;
   logic vld_ff [TOTAL];
   logic deg_ff [NORM_LAT];
   logic signed [UW-1:0] cos_w, sin_w;
   logic signed [UW-1:0] cd_ff [DLY];
   logic signed [UW-1:0] sd_ff [DLY];
   logic signed [UW-1:0] ux, uy, uz;
   rsp_type mat;
   logic rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_data_ff, skid_data_ff;

   assign en = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   aar_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock   (clock),
      .en      (en),
      .angle   (req_data.angle_rad),
      .cos_out (cos_w),
      .sin_out (sin_w)
   );

   aar_norm u_norm (
      .clock  (clock),
      .en     (en),
      .axis_x (req_data.axis_x),
      .axis_y (req_data.axis_y),
      .axis_z (req_data.axis_z),
      .ux     (ux),
      .uy     (uy),
      .uz     (uz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < TOTAL; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         deg_ff[0] <= (req_data.axis_x == '0) && (req_data.axis_y == '0)
                      && (req_data.axis_z == '0);
         for (int i = 1; i < NORM_LAT; i++) begin
            deg_ff[i] <= deg_ff[i-1];
         end
         cd_ff[0] <= cos_w;
         sd_ff[0] <= sin_w;
         for (int i = 1; i < DLY; i++) begin
            cd_ff[i] <= cd_ff[i-1];
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   aar_mat u_mat (
      .clock (clock),
      .en    (en),
      .ux    (ux),
      .uy    (uy),
      .uz    (uz),
      .c     (cd_ff[DLY-1]),
      .s     (sd_ff[DLY-1]),
      .deg   (deg_ff[NORM_LAT-1]),
      .mat   (mat)
   );

   // output word plus skid; the pipe freezes only while the skid is occupied
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!skid_valid_ff) begin
         if (rsp_valid_ff && rsp_stall) begin
            skid_valid_ff <= vld_ff[TOTAL-1];
         end else begin
            rsp_valid_ff <= vld_ff[TOTAL-1];
         end
      end else if (!rsp_stall) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         if (rsp_valid_ff && rsp_stall) begin
            skid_data_ff <= mat;
         end else begin
            rsp_data_ff <= mat;
         end
      end else if (!rsp_stall) begin
         rsp_data_ff <= skid_data_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a word while output is empty");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(vld_ff[TOTAL-1]))
      else $error("pipe advanced while skid was full");

   a_degenerate_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate_axis) |->
         (rsp_data.m00 == (DATA_WIDTH'(1) <<< FRAC_BITS) && rsp_data.m01 == '0
          && rsp_data.m10 == '0 && rsp_data.m22 == (DATA_WIDTH'(1) <<< FRAC_BITS)))
      else $error("degenerate axis without identity matrix");
`endif
endmodule
`default_nettype wire
